FILE: hw/rtl/grid_neighbor_rank_generator_assert.svh
// Assertion macros used by the grid neighbor rank generator checker.
// Depends on a clock named clock and an active-high reset named reset in scope.
`ifndef GRID_NEIGHBOR_RANK_GENERATOR_ASSERT_SVH
`define GRID_NEIGHBOR_RANK_GENERATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GNRG_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GNRG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/gnrg_pkg.sv
// Shared widths, codes and controller/datapath interface types for the
// grid neighbor rank generator. No dependencies.
package gnrg_pkg;

   localparam int MAX_PROCS_DEFAULT = 1024;

   localparam int RANK_W     = 10;
   localparam int CNT_W      = 11;
   localparam int SIDE_W     = 6;
   localparam int SQ_W       = 2 * SIDE_W;
   localparam int ID_W       = CNT_W + SIDE_W;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = CNT_W;
   localparam int DIV_STEP_W = $clog2(CNT_W);

   localparam logic [CSR_IDX_W-1:0] REG_PROCESS_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_WRAP_MODE     = CSR_IDX_W'(1);

   localparam logic [STATUS_W-1:0] RSP_NEIGHBOR = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] RSP_NONE     = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] RSP_RANGE    = STATUS_W'(2);

   localparam logic [1:0] OFS_MINUS = 2'd0;
   localparam logic [1:0] OFS_ZERO  = 2'd1;
   localparam logic [1:0] OFS_PLUS  = 2'd2;

   typedef struct packed {
      logic load;
      logic emit_error;
      logic sqrt_step;
      logic round;
      logic div_cnt;
      logic cand_dec;
      logic set_grid;
      logic div_rank;
      logic set_coord;
      logic scan_step;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic range_err;
      logic sqrt_last;
      logic div_done;
      logic div_rem_zero;
      logic scan_last;
   } stat_type;

endpackage

FILE: hw/rtl/gnrg_div.sv
// Restoring divider, one quotient bit per cycle, for the grid neighbor
// rank generator. Depends on gnrg_pkg.
module gnrg_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [gnrg_pkg::CNT_W-1:0]   dividend,
   input  logic [gnrg_pkg::SIDE_W-1:0]  divisor,
   output logic                         done,
   output logic [gnrg_pkg::CNT_W-1:0]   quotient,
   output logic [gnrg_pkg::SIDE_W-1:0]  remainder
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [gnrg_pkg::DIV_STEP_W-1:0]   step_ff, step_in;
   logic [gnrg_pkg::CNT_W-1:0]        quo_ff, quo_in;
   logic [gnrg_pkg::SIDE_W-1:0]       rem_ff, rem_in;
   logic [gnrg_pkg::SIDE_W-1:0]       dsr_ff, dsr_in;
   logic [gnrg_pkg::SIDE_W:0]         shifted;
   logic [gnrg_pkg::SIDE_W:0]         diff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      shifted  = {rem_ff, quo_ff[gnrg_pkg::CNT_W-1]};
      diff     = shifted - {1'b0, dsr_ff};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = diff[gnrg_pkg::SIDE_W-1:0];
            quo_in = {quo_ff[gnrg_pkg::CNT_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[gnrg_pkg::SIDE_W-1:0];
            quo_in = {quo_ff[gnrg_pkg::CNT_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == gnrg_pkg::DIV_STEP_W'(gnrg_pkg::CNT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: hw/rtl/gnrg_dp.sv
// Datapath of the grid neighbor rank generator: configuration registers,
// square root, divisor search, neighbor scan and result register.
// Depends on gnrg_pkg and gnrg_div.
module gnrg_dp #(
   parameter int MAX_PROCS = gnrg_pkg::MAX_PROCS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [gnrg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gnrg_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic [gnrg_pkg::RANK_W-1:0]      req_rank,
   input  gnrg_pkg::cmd_type                cmd,
   output gnrg_pkg::stat_type               stat,
   output logic                             rsp_strobe,
   output logic [gnrg_pkg::RANK_W-1:0]      rsp_neighbor_rank,
   output logic [gnrg_pkg::STATUS_W-1:0]    rsp_status,
   output logic                             rsp_last
);

   logic [gnrg_pkg::CNT_W-1:0]     process_count_ff, process_count_in;
   logic                           wrap_mode_ff, wrap_mode_in;
   logic [gnrg_pkg::CNT_W-1:0]     cnt_eff;

   logic [gnrg_pkg::RANK_W-1:0]    rank_ff, rank_in;
   logic [gnrg_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [gnrg_pkg::SIDE_W-1:0]    sqrt_ff, sqrt_in;
   logic [2:0]                     sbit_ff, sbit_in;
   logic [gnrg_pkg::SIDE_W-1:0]    cols_ff, cols_in;
   logic [gnrg_pkg::CNT_W-1:0]     rows_ff, rows_in;
   logic [gnrg_pkg::SIDE_W-1:0]    col_ff, col_in;
   logic [gnrg_pkg::CNT_W-1:0]     row_ff, row_in;
   logic [1:0]                     dc_ff, dc_in;
   logic [1:0]                     dr_ff, dr_in;
   logic                           pend_valid_ff, pend_valid_in;
   logic [gnrg_pkg::RANK_W-1:0]    pend_id_ff, pend_id_in;

   logic                           rsp_strobe_ff, rsp_strobe_in;
   logic [gnrg_pkg::RANK_W-1:0]    rsp_nb_ff, rsp_nb_in;
   logic [gnrg_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic [gnrg_pkg::SIDE_W-1:0]    trial;
   logic [gnrg_pkg::SQ_W-1:0]      trial_sq;
   logic [gnrg_pkg::SQ_W-1:0]      sqrt_sq;
   logic [gnrg_pkg::SQ_W-1:0]      excess;

   logic                           div_start;
   logic [gnrg_pkg::CNT_W-1:0]     div_dividend;
   logic                           div_done;
   logic [gnrg_pkg::CNT_W-1:0]     div_quo;
   logic [gnrg_pkg::SIDE_W-1:0]    div_rem;

   logic [gnrg_pkg::SIDE_W-1:0]    cols_m1;
   logic [gnrg_pkg::CNT_W-1:0]     rows_m1;
   logic                           col_lo, col_hi, row_lo, row_hi;
   logic [gnrg_pkg::SIDE_W-1:0]    nc;
   logic [gnrg_pkg::CNT_W-1:0]     nr;
   logic                           ok_c, ok_r;
   logic [gnrg_pkg::ID_W-1:0]      id_full;
   logic                           hit;

   // Configuration port.
   always_comb begin
      process_count_in = process_count_ff;
      wrap_mode_in     = wrap_mode_ff;
      if (csr_write_enable) begin
         case (csr_index)
            gnrg_pkg::REG_PROCESS_COUNT: process_count_in = csr_write_data;
            gnrg_pkg::REG_WRAP_MODE:     wrap_mode_in     = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (32'(process_count_ff) > 32'(MAX_PROCS)) begin
         cnt_eff = gnrg_pkg::CNT_W'(MAX_PROCS);
      end else begin
         cnt_eff = process_count_ff;
      end
   end

   // Shared divider: count by candidate columns, then rank by columns.
   assign div_start    = cmd.div_cnt | cmd.div_rank;
   assign div_dividend = cmd.div_rank ? gnrg_pkg::CNT_W'(rank_ff) : cnt_ff;

   gnrg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (cols_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Square root and rounding.
   assign trial    = sqrt_ff | (gnrg_pkg::SIDE_W'(1) << sbit_ff);
   assign trial_sq = gnrg_pkg::SQ_W'(trial) * gnrg_pkg::SQ_W'(trial);
   assign sqrt_sq  = gnrg_pkg::SQ_W'(sqrt_ff) * gnrg_pkg::SQ_W'(sqrt_ff);
   assign excess   = gnrg_pkg::SQ_W'(cnt_ff) - sqrt_sq;

   // Neighbor coordinate selection.
   assign cols_m1 = cols_ff - 1'b1;
   assign rows_m1 = rows_ff - 1'b1;
   assign col_lo  = (col_ff == '0);
   assign col_hi  = (col_ff == cols_m1);
   assign row_lo  = (row_ff == '0);
   assign row_hi  = (row_ff == rows_m1);

   always_comb begin
      case (dc_ff)
         gnrg_pkg::OFS_MINUS: begin
            nc   = col_lo ? cols_m1 : col_ff - 1'b1;
            ok_c = wrap_mode_ff | ~col_lo;
         end
         gnrg_pkg::OFS_ZERO: begin
            nc   = col_ff;
            ok_c = 1'b1;
         end
         gnrg_pkg::OFS_PLUS: begin
            nc   = col_hi ? '0 : col_ff + 1'b1;
            ok_c = wrap_mode_ff | ~col_hi;
         end
         default: begin
            nc   = col_ff;
            ok_c = 1'b0;
         end
      endcase
      case (dr_ff)
         gnrg_pkg::OFS_MINUS: begin
            nr   = row_lo ? rows_m1 : row_ff - 1'b1;
            ok_r = wrap_mode_ff | ~row_lo;
         end
         gnrg_pkg::OFS_ZERO: begin
            nr   = row_ff;
            ok_r = 1'b1;
         end
         gnrg_pkg::OFS_PLUS: begin
            nr   = row_hi ? '0 : row_ff + 1'b1;
            ok_r = wrap_mode_ff | ~row_hi;
         end
         default: begin
            nr   = row_ff;
            ok_r = 1'b0;
         end
      endcase
   end

   assign id_full = gnrg_pkg::ID_W'(nr) * gnrg_pkg::ID_W'(cols_ff) + gnrg_pkg::ID_W'(nc);
   assign hit     = ok_c & ok_r & (id_full != gnrg_pkg::ID_W'(rank_ff));

   always_comb begin
      rank_in       = rank_ff;
      cnt_in        = cnt_ff;
      sqrt_in       = sqrt_ff;
      sbit_in       = sbit_ff;
      cols_in       = cols_ff;
      rows_in       = rows_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      dc_in         = dc_ff;
      dr_in         = dr_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      rsp_strobe_in = 1'b0;
      rsp_nb_in     = pend_id_ff;
      rsp_status_in = gnrg_pkg::RSP_NEIGHBOR;
      rsp_last_in   = 1'b0;

      if (cmd.load) begin
         rank_in       = req_rank;
         cnt_in        = cnt_eff;
         sqrt_in       = '0;
         sbit_in       = 3'(gnrg_pkg::SIDE_W - 1);
         pend_valid_in = 1'b0;
      end
      if (cmd.sqrt_step) begin
         if (trial_sq <= gnrg_pkg::SQ_W'(cnt_ff)) begin
            sqrt_in = trial;
         end
         sbit_in = sbit_ff - 1'b1;
      end
      if (cmd.round) begin
         cols_in = (excess > gnrg_pkg::SQ_W'(sqrt_ff)) ? sqrt_ff + 1'b1 : sqrt_ff;
      end
      if (cmd.cand_dec) begin
         cols_in = cols_ff - 1'b1;
      end
      if (cmd.set_grid) begin
         rows_in = div_quo;
      end
      if (cmd.set_coord) begin
         col_in = div_rem;
         row_in = div_quo;
         dc_in  = gnrg_pkg::OFS_MINUS;
         dr_in  = gnrg_pkg::OFS_MINUS;
      end
      if (cmd.scan_step) begin
         if (dr_ff == gnrg_pkg::OFS_PLUS) begin
            dr_in = gnrg_pkg::OFS_MINUS;
            dc_in = dc_ff + 1'b1;
         end else begin
            dr_in = dr_ff + 1'b1;
         end
         if (hit) begin
            rsp_strobe_in = pend_valid_ff;
            pend_id_in    = id_full[gnrg_pkg::RANK_W-1:0];
            pend_valid_in = 1'b1;
         end
      end
      if (cmd.flush) begin
         rsp_strobe_in = 1'b1;
         rsp_last_in   = 1'b1;
         if (!pend_valid_ff) begin
            rsp_nb_in     = '0;
            rsp_status_in = gnrg_pkg::RSP_NONE;
         end
      end
      if (cmd.emit_error) begin
         rsp_strobe_in = 1'b1;
         rsp_nb_in     = '0;
         rsp_status_in = gnrg_pkg::RSP_RANGE;
         rsp_last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         process_count_ff <= gnrg_pkg::CNT_W'(1);
         wrap_mode_ff     <= 1'b1;
         pend_valid_ff    <= 1'b0;
         rsp_strobe_ff    <= 1'b0;
         sbit_ff          <= '0;
         dc_ff            <= '0;
         dr_ff            <= '0;
      end else begin
         process_count_ff <= process_count_in;
         wrap_mode_ff     <= wrap_mode_in;
         pend_valid_ff    <= pend_valid_in;
         rsp_strobe_ff    <= rsp_strobe_in;
         sbit_ff          <= sbit_in;
         dc_ff            <= dc_in;
         dr_ff            <= dr_in;
      end
   end

   always_ff @(posedge clock) begin
      rank_ff       <= rank_in;
      cnt_ff        <= cnt_in;
      sqrt_ff       <= sqrt_in;
      cols_ff       <= cols_in;
      rows_ff       <= rows_in;
      col_ff        <= col_in;
      row_ff        <= row_in;
      pend_id_ff    <= pend_id_in;
      rsp_nb_ff     <= rsp_nb_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign stat.range_err    = (gnrg_pkg::CNT_W'(rank_ff) >= cnt_ff);
   assign stat.sqrt_last    = (sbit_ff == '0);
   assign stat.div_done     = div_done;
   assign stat.div_rem_zero = (div_rem == '0);
   assign stat.scan_last    = (dc_ff == gnrg_pkg::OFS_PLUS) && (dr_ff == gnrg_pkg::OFS_PLUS);

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_neighbor_rank = rsp_nb_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

FILE: hw/rtl/gnrg_ctrl.sv
// Controller state machine of the grid neighbor rank generator; sequences
// the datapath through commands and reads back its status. Depends on gnrg_pkg.
module gnrg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  gnrg_pkg::stat_type  stat,
   output gnrg_pkg::cmd_type   cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_SQRT,
      S_ROUND,
      S_DIV_START,
      S_DIV_WAIT,
      S_RANK_START,
      S_RANK_WAIT,
      S_SCAN,
      S_FLUSH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.range_err) begin
               cmd.emit_error = 1'b1;
               state_in       = S_IDLE;
            end else begin
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (stat.sqrt_last) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            state_in  = S_DIV_START;
         end
         S_DIV_START: begin
            cmd.div_cnt = 1'b1;
            state_in    = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (stat.div_done) begin
               if (stat.div_rem_zero) begin
                  cmd.set_grid = 1'b1;
                  state_in     = S_RANK_START;
               end else begin
                  cmd.cand_dec = 1'b1;
                  state_in     = S_DIV_START;
               end
            end
         end
         S_RANK_START: begin
            cmd.div_rank = 1'b1;
            state_in     = S_RANK_WAIT;
         end
         S_RANK_WAIT: begin
            if (stat.div_done) begin
               cmd.set_coord = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

FILE: hw/rtl/grid_neighbor_rank_generator.sv
// Top level of the grid neighbor rank generator: controller plus datapath.
// Depends on gnrg_pkg, gnrg_ctrl and gnrg_dp.
//
// Usage: write process_count (index 0) and wrap_mode (index 1) through the
// csr port while busy is low. A request beat is taken when start is high and
// busy is low; req_rank is sampled at that edge. The block lays the count out
// on a grid, then emits one rsp beat with rsp_strobe high for each neighbor
// found (a none status beat if there is none), the final beat marked by
// rsp_last. An out-of-range rank gives a single status beat. Otherwise the
// divisor search tries k candidate column counts (1 for a perfect square, up
// to 32 for a prime count near 1024); each try is one pass of the bit-serial
// divider. The last beat is on the ports in the first cycle in which busy is
// low, and a new request can be taken in that same cycle.
// Results cannot be held off by the receiver. Reset clears the controller,
// drops any request in progress and sets process_count to 1 and wrap_mode to 1.
module grid_neighbor_rank_generator #(
   parameter int MAX_PROCS = gnrg_pkg::MAX_PROCS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [gnrg_pkg::RANK_W-1:0]      req_rank,
   output logic                             rsp_strobe,
   output logic [gnrg_pkg::RANK_W-1:0]      rsp_neighbor_rank,
   output logic [gnrg_pkg::STATUS_W-1:0]    rsp_status,
   output logic                             rsp_last,
   input  logic                             csr_write_enable,
   input  logic [gnrg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gnrg_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   gnrg_pkg::cmd_type  cmd;
   gnrg_pkg::stat_type stat;

   gnrg_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   gnrg_dp #(
      .MAX_PROCS (MAX_PROCS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_rank          (req_rank),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_strobe        (rsp_strobe),
      .rsp_neighbor_rank (rsp_neighbor_rank),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

endmodule

FILE: hw/rtl/gnrg_checker.sv
// Port-level checker for the grid neighbor rank generator and its bind.
// Depends on gnrg_pkg and grid_neighbor_rank_generator_assert.svh.
`include "grid_neighbor_rank_generator_assert.svh"

module gnrg_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_strobe,
   input logic [gnrg_pkg::RANK_W-1:0]      rsp_neighbor_rank,
   input logic [gnrg_pkg::STATUS_W-1:0]    rsp_status,
   input logic                             rsp_last
);

   logic status_beat;
   logic status_ok;
   logic final_beat;
   logic middle_beat;

   assign status_beat = rsp_strobe && (rsp_status != gnrg_pkg::RSP_NEIGHBOR);
   assign status_ok   = rsp_last && (rsp_neighbor_rank == '0);
   assign final_beat  = rsp_strobe && rsp_last;
   assign middle_beat = rsp_strobe && !rsp_last;

   `GNRG_ASSERT_SAME(a_status_beat_alone, status_beat, status_ok, "status beat not final or nonzero")
   `GNRG_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy, "accepted request did not raise busy")
   `GNRG_ASSERT_SAME(a_last_when_idle, final_beat, !busy, "last beat seen while still busy")
   `GNRG_ASSERT_SAME(a_more_when_busy, middle_beat, busy, "non-final beat seen while idle")

endmodule

bind grid_neighbor_rank_generator gnrg_checker u_gnrg_checker (.*);
